// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rtl; compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/mktd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_pkg
// Shared types, codes and the Morse lookup for the key timing decoder.
// ----------------------------------------------------------------------------
package mktd_pkg;

  localparam int TIMER_WIDTH  = 16;
  localparam int CFG_WIDTH    = 16;
  localparam int MAX_CODE_LEN = 5;
  localparam int COUNT_WIDTH  = 3;
  localparam int KIND_WIDTH   = 3;
  localparam int ASCII_WIDTH  = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int TABLE_SIZE   = 36;

  // event kinds
  localparam logic [KIND_WIDTH-1:0] KIND_DOT     = 3'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_DASH    = 3'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_BAD     = 3'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_LETTER  = 3'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_NOMATCH = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOT_MIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN    = 2'd3;

  localparam logic [CFG_WIDTH-1:0] DOT_MIN_RESET    = 16'd469;
  localparam logic [CFG_WIDTH-1:0] DASH_MIN_RESET   = 16'd3125;
  localparam logic [CFG_WIDTH-1:0] DASH_LIMIT_RESET = 16'd6250;
  localparam logic [CFG_WIDTH-1:0] GAP_MIN_RESET    = 16'd6250;

  // classified edge passed from front to back
  typedef struct packed {
    logic                  is_letter;
    logic [KIND_WIDTH-1:0] kind;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [KIND_WIDTH-1:0]   event_kind;
    logic [ASCII_WIDTH-1:0]  letter;
    logic [MAX_CODE_LEN-1:0] code_bits;
    logic [COUNT_WIDTH-1:0]  code_length;
  } result_t;

  // queue status between modules
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // table: symbols first in bit 0, 1 = dash
  localparam logic [MAX_CODE_LEN-1:0] PAT_BITS [TABLE_SIZE] = '{
    5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
    5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
    5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
    5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
    5'b01101, 5'b00011, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
    5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111, 5'b11111
  };

  localparam logic [COUNT_WIDTH-1:0] PAT_LEN [TABLE_SIZE] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [ASCII_WIDTH-1:0] PAT_ASCII [TABLE_SIZE] = '{
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C,
    7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
    7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
    7'h59, 7'h5A, 7'h31, 7'h32, 7'h33, 7'h34,
    7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
  };

  // ascii of the matching entry, 0 when none matches; bits above len are zero
  function automatic logic [ASCII_WIDTH-1:0] match_code(
    input logic [MAX_CODE_LEN-1:0] bits,
    input logic [COUNT_WIDTH-1:0]  len
  );
    logic [ASCII_WIDTH-1:0] ascii;
    ascii = '0;
    for (int e = 0; e < TABLE_SIZE; e++) begin
      if (bits == PAT_BITS[e] && len == PAT_LEN[e]) begin
        ascii = PAT_ASCII[e];
      end
    end
    return ascii;
  endfunction

endpackage

// ===== rtl/mktd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_front
// Holds thresholds and edge timing; classifies each key edge into a command.
// ----------------------------------------------------------------------------
module mktd_front
  import mktd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  output logic                   cfg_ready,
  input  logic                   accept,
  input  logic [TIMER_WIDTH-1:0] capture_time,
  output logic                   cmd_valid,
  output cmd_t                   cmd
);

  logic [CFG_WIDTH-1:0]   dot_min;
  logic [CFG_WIDTH-1:0]   dash_min;
  logic [CFG_WIDTH-1:0]   dash_limit;
  logic [CFG_WIDTH-1:0]   gap_min;
  logic [TIMER_WIDTH-1:0] last_edge_time;
  logic                   key_is_down;
  logic [TIMER_WIDTH-1:0] elapsed;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_min    <= DOT_MIN_RESET;
      dash_min   <= DASH_MIN_RESET;
      dash_limit <= DASH_LIMIT_RESET;
      gap_min    <= GAP_MIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DOT_MIN:    dot_min    <= cfg_data;
        REG_DASH_MIN:   dash_min   <= cfg_data;
        REG_DASH_LIMIT: dash_limit <= cfg_data;
        REG_GAP_MIN:    gap_min    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // edge timing, wraps modulo the timer width
  assign elapsed = capture_time - last_edge_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      key_is_down    <= 1'b0;
    end else if (accept) begin
      last_edge_time <= capture_time;
      key_is_down    <= ~key_is_down;
    end
  end

  // classify press length or letter-ending gap
  always_comb begin
    cmd.is_letter = ~key_is_down;
    if (elapsed >= dot_min && elapsed < dash_min) begin
      cmd.kind = KIND_DOT;
    end else if (elapsed >= dash_min && elapsed < dash_limit) begin
      cmd.kind = KIND_DASH;
    end else begin
      cmd.kind = KIND_BAD;
    end
    cmd_valid = accept && (key_is_down || elapsed > gap_min);
  end

endmodule

// ===== rtl/mktd_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_cmd_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module mktd_cmd_queue
  import mktd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  cmd_t      wr_cmd,
  input  logic      rd_en,
  output cmd_t      rd_cmd,
  output q_status_t status
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign rd_cmd       = entries[rd_ptr];
  assign status.full  = count[1];
  assign status.empty = (count == 2'd0);

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/mktd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_back
// Builds the symbol code, matches letters and queues result items.
// ----------------------------------------------------------------------------
module mktd_back
  import mktd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  q_status_t cmd_status,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      res_pop,
  output result_t   res,
  output q_status_t res_status
);

  logic [MAX_CODE_LEN-1:0] symbol_bits;
  logic [COUNT_WIDTH-1:0]  symbol_count;
  logic                    bad_element_seen;
  logic [MAX_CODE_LEN-1:0] symbol_bits_next;
  logic [COUNT_WIDTH-1:0]  symbol_count_next;
  logic                    bad_element_seen_next;
  logic [ASCII_WIDTH-1:0]  ascii;
  result_t                 res_new;

  result_t                 slots [2];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;

  localparam logic [COUNT_WIDTH-1:0] MAX_LEN  = COUNT_WIDTH'(MAX_CODE_LEN);
  localparam logic [COUNT_WIDTH-1:0] TOO_LONG = COUNT_WIDTH'(MAX_CODE_LEN + 1);

  assign res_status.full  = count[1];
  assign res_status.empty = (count == 2'd0);
  assign res              = slots[rd_ptr];

  // take a command whenever the result queue has room
  assign cmd_pop = !cmd_status.empty && !res_status.full;

  // code update and letter match
  always_comb begin
    symbol_bits_next      = symbol_bits;
    symbol_count_next     = symbol_count;
    bad_element_seen_next = bad_element_seen;
    ascii                 = '0;
    res_new               = '0;
    if (cmd.is_letter) begin
      if (!bad_element_seen && symbol_count != '0 && symbol_count <= MAX_LEN) begin
        ascii = match_code(symbol_bits, symbol_count);
      end
      res_new.event_kind    = (ascii != '0) ? KIND_LETTER : KIND_NOMATCH;
      res_new.letter        = ascii;
      res_new.code_bits     = symbol_bits;
      res_new.code_length   = symbol_count;
      symbol_bits_next      = '0;
      symbol_count_next     = '0;
      bad_element_seen_next = 1'b0;
    end else begin
      if (cmd.kind == KIND_BAD) begin
        bad_element_seen_next = 1'b1;
      end
      if (symbol_count < MAX_LEN) begin
        if (cmd.kind == KIND_DASH) begin
          symbol_bits_next = symbol_bits | (MAX_CODE_LEN'(1) << symbol_count);
        end
        symbol_count_next = symbol_count + COUNT_WIDTH'(1);
      end else begin
        symbol_count_next = TOO_LONG;
      end
      res_new.event_kind  = cmd.kind;
      res_new.letter      = '0;
      res_new.code_bits   = symbol_bits_next;
      res_new.code_length = symbol_count_next;
    end
  end

  // code state
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_bits      <= '0;
      symbol_count     <= '0;
      bad_element_seen <= 1'b0;
    end else if (cmd_pop) begin
      symbol_bits      <= symbol_bits_next;
      symbol_count     <= symbol_count_next;
      bad_element_seen <= bad_element_seen_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      slots[wr_ptr] <= res_new;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (cmd_pop) begin
        wr_ptr <= ~wr_ptr;
      end
      if (res_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({cmd_pop, res_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/morse_key_timing_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_decoder_unit: Morse key timing decoder, queue interface
// Path: a classified edge enters the two-entry command queue; its result goes
// into the two-entry result queue, whose head drives the outputs. One edge per
// cycle while not full; the queues let front and back stall independently.
// Reset: synchronous rst restores default thresholds and clears code and queues.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module morse_key_timing_decoder_unit
  import mktd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [TIMER_WIDTH-1:0]  capture_time,
  output logic                    empty,
  input  logic                    pop,
  output logic [KIND_WIDTH-1:0]   event_kind,
  output logic [ASCII_WIDTH-1:0]  letter,
  output logic [MAX_CODE_LEN-1:0] code_bits,
  output logic [COUNT_WIDTH-1:0]  code_length,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_WIDTH-1:0]    cfg_data
);

  logic      in_accept;
  logic      cmd_valid;
  cmd_t      cmd_in;
  cmd_t      cmd_head;
  logic      cmd_pop;
  q_status_t cmd_status;
  q_status_t res_status;
  result_t   res;
  logic      res_pop;

  assign full      = cmd_status.full;
  assign in_accept = push && !cmd_status.full;
  assign empty     = res_status.empty;
  assign res_pop   = pop && !res_status.empty;

  assign event_kind  = res.event_kind;
  assign letter      = res.letter;
  assign code_bits   = res.code_bits;
  assign code_length = res.code_length;

  // edge classification
  mktd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg_ready    (cfg_ready),
    .accept       (in_accept),
    .capture_time (capture_time),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd_in)
  );

  // decoupling queue
  mktd_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_valid),
    .wr_cmd (cmd_in),
    .rd_en  (cmd_pop),
    .rd_cmd (cmd_head),
    .status (cmd_status)
  );

  // code assembly, match and result queue
  mktd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_status (cmd_status),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .res_pop    (res_pop),
    .res        (res),
    .res_status (res_status)
  );

  // back only consumes real commands and never sits on work it could do
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, cmd_pop, !cmd_status.empty)
  `ASSERT_IMPLIES(a_back_drains, clk, rst, !cmd_status.empty && !res_status.full, cmd_pop)
  // every consumed command leaves a result waiting
  `ASSERT_NEXT(a_cmd_gives_result, clk, rst, cmd_pop, !res_status.empty)

endmodule
